/* rtl/length_framed_packet_deframer_assert.svh */
// assertion macros for the length framed packet deframer
`ifndef LENGTH_FRAMED_PACKET_DEFRAMER_ASSERT_SVH
`define LENGTH_FRAMED_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LFPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfpd same-cycle check failed");

// next-cycle implication, checked outside reset
`define LFPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfpd next-cycle check failed");

`endif

/* rtl/lfpd_pkg.sv */
// types and constants shared by the deframer modules
package lfpd_pkg;

    localparam logic [7:0] START_BYTE    = 8'h68;
    localparam logic [7:0] STOP_BYTE     = 8'h16;
    localparam logic [7:0] TIMEOUT_RESET = 8'd2;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_TRAILER = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    localparam logic [1:0] ST_WAIT    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_SYNC    = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    typedef struct packed {
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_data;
        logic [1:0] frame_status;
    } lfpd_result_t;

endpackage

/* rtl/lfpd_fsm.sv */
// frame state machine: phase, length, count and start tick per word
module lfpd_fsm
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           now_tick,
    input  logic [7:0]           timeout_ticks,
    output lfpd_pkg::lfpd_result_t res
);
    import lfpd_pkg::*;

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [7:0] frame_length_reg;
    logic [7:0] frame_length_next;
    logic [7:0] byte_count_reg;
    logic [7:0] byte_count_next;
    logic [7:0] start_tick_reg;
    logic [7:0] start_tick_next;
    logic [7:0] count_inc;
    logic [7:0] elapsed;

    assign count_inc = byte_count_reg + 8'd1;
    assign elapsed   = now_tick - start_tick_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        byte_count_next   = byte_count_reg;
        start_tick_next   = start_tick_reg;
        res.store_valid   = 1'b0;
        res.store_index   = 8'd0;
        res.store_data    = 8'd0;
        res.frame_status  = ST_WAIT;
        case (phase_reg)
            PH_LENGTH:
            begin
                frame_length_next = rx_byte;
                byte_count_next   = 8'd0;
                res.store_valid   = 1'b1;
                res.store_data    = rx_byte;
                phase_next        = (rx_byte == 8'd0) ? PH_TRAILER : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                byte_count_next = count_inc;
                res.store_valid = 1'b1;
                res.store_index = count_inc;
                res.store_data  = rx_byte;
                if (count_inc == frame_length_reg)
                begin
                    phase_next = PH_TRAILER;
                end
            end
            PH_TRAILER:
            begin
                if (rx_byte == STOP_BYTE)
                begin
                    phase_next       = PH_DONE;
                    res.frame_status = ST_DONE;
                end
                else if (rx_byte == START_BYTE)
                begin
                    phase_next       = PH_LENGTH;
                    res.frame_status = ST_SYNC;
                end
                else if (elapsed > timeout_ticks)
                begin
                    phase_next       = PH_DONE;
                    res.frame_status = ST_TIMEOUT;
                end
            end
            default:
            begin
                if (rx_byte == START_BYTE)
                begin
                    phase_next      = PH_LENGTH;
                    start_tick_next = now_tick;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            frame_length_reg <= 8'd0;
            byte_count_reg   <= 8'd0;
            start_tick_reg   <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            byte_count_reg   <= byte_count_next;
            start_tick_reg   <= start_tick_next;
        end
    end

`include "length_framed_packet_deframer_assert.svh"

    `LFPD_ASSERT_NEXT(a_start_seen, step_en && (phase_reg == PH_HUNT) && (rx_byte == START_BYTE), (phase_reg == PH_LENGTH) && (start_tick_reg == $past(now_tick)))
    `LFPD_ASSERT_NOW(a_no_overrun, phase_reg == PH_PAYLOAD, byte_count_reg < frame_length_reg)
    `LFPD_ASSERT_NOW(a_status_no_store, res.frame_status != ST_WAIT, !res.store_valid)
    `LFPD_ASSERT_NEXT(a_done_hunts, step_en && (res.frame_status == ST_DONE), phase_reg == PH_DONE)

endmodule

/* rtl/length_framed_packet_deframer.sv */
// a word accepted into the input register moves on to the result register once that register is free
// throughput: one word per cycle while results are taken, input and result registers overlap
// the frame state advances as a word moves from the input to the result register
// reset: asynchronous active low, clears both valids and the frame state,
// sets the trailer timeout to 2 ticks
module length_framed_packet_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic [7:0] now_tick,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       store_valid,
    output logic [7:0] store_index,
    output logic [7:0] store_data,
    output logic [1:0] frame_status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] trailer_timeout_ticks
);
    import lfpd_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   rx_byte_reg;
    logic [7:0]   now_tick_reg;
    logic         out_valid_reg;
    lfpd_result_t out_reg;
    logic [7:0]   timeout_reg;
    logic         step_en;
    lfpd_result_t step_res;

    assign step_en   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || step_en;
    assign cfg_ready = 1'b1;

    lfpd_fsm u_fsm
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .rx_byte       (rx_byte_reg),
        .now_tick      (now_tick_reg),
        .timeout_ticks (timeout_reg),
        .res           (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= trailer_timeout_ticks;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rx_byte_reg  <= rx_byte;
            now_tick_reg <= now_tick;
        end
        if (step_en)
        begin
            out_reg <= step_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign store_valid  = out_reg.store_valid;
    assign store_index  = out_reg.store_index;
    assign store_data   = out_reg.store_data;
    assign frame_status = out_reg.frame_status;

endmodule
